FILE: hdl/neutrino_pz_w_mass_solver_macros.svh
// assertion macros used by the neutrino pz solver top level
`ifndef NEUTRINO_PZ_W_MASS_SOLVER_MACROS_SVH
`define NEUTRINO_PZ_W_MASS_SOLVER_MACROS_SVH

// same-cycle implication
`define NPZ_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NPZ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/npz_pkg.sv
// shared types and constants of the neutrino pz solver
package npz_pkg;

   localparam logic [15:0] W_MASS_RESET = 16'd5146;

   typedef struct packed {
      logic valid;
      logic solved;
   } ctl_type;

endpackage

FILE: hdl/npz_mul.sv
// signed multiplier split into four partial products over three register stages
module npz_mul #(
   parameter int WA = 8,
   parameter int WB = 8,
   parameter int SW = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  npz_pkg::ctl_type          ctl_i,
   input  logic signed [WA-1:0]      a_i,
   input  logic signed [WB-1:0]      b_i,
   input  logic [SW-1:0]             side_i,
   output npz_pkg::ctl_type          ctl_o,
   output logic signed [WA+WB-1:0]   p_o,
   output logic [SW-1:0]             side_o
);
   localparam int HA = (WA + 1) / 2;
   localparam int HB = (WB + 1) / 2;
   localparam int UA = WA - HA;
   localparam int UB = WB - HB;
   localparam int PW = WA + WB;

   npz_pkg::ctl_type ctl1_ff, ctl2_ff, ctl3_ff;
   logic [SW-1:0]    side1_ff, side2_ff, side3_ff;
   logic [WA-1:0]    mag_a_ff, mag_a_in;
   logic [WB-1:0]    mag_b_ff, mag_b_in;
   logic             neg1_ff, neg2_ff;
   logic [UA+UB-1:0] hh_ff;
   logic [UA+HB-1:0] hl_ff;
   logic [HA+UB-1:0] lh_ff;
   logic [HA+HB-1:0] ll_ff;
   logic [PW-1:0]    sum;
   logic [PW-1:0]    p_ff, p_in;

   assign mag_a_in = a_i[WA-1] ? (WA'(~a_i) + WA'(1)) : WA'(a_i);
   assign mag_b_in = b_i[WB-1] ? (WB'(~b_i) + WB'(1)) : WB'(b_i);

   assign sum = (PW'(hh_ff) << (HA + HB)) + (PW'(hl_ff) << HA)
              + (PW'(lh_ff) << HB) + PW'(ll_ff);
   assign p_in = neg2_ff ? (~sum + PW'(1)) : sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else if (en) begin
         ctl1_ff <= ctl_i;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_a_ff <= mag_a_in;
         mag_b_ff <= mag_b_in;
         neg1_ff  <= a_i[WA-1] ^ b_i[WB-1];
         side1_ff <= side_i;
         hh_ff    <= mag_a_ff[WA-1:HA] * mag_b_ff[WB-1:HB];
         hl_ff    <= mag_a_ff[WA-1:HA] * mag_b_ff[HB-1:0];
         lh_ff    <= mag_a_ff[HA-1:0] * mag_b_ff[WB-1:HB];
         ll_ff    <= mag_a_ff[HA-1:0] * mag_b_ff[HB-1:0];
         neg2_ff  <= neg1_ff;
         side2_ff <= side1_ff;
         p_ff     <= p_in;
         side3_ff <= side2_ff;
      end
   end

   assign ctl_o  = ctl3_ff;
   assign p_o    = $signed(p_ff);
   assign side_o = side3_ff;

endmodule

FILE: hdl/npz_sqrt_cell.sv
// one root bit of the digit-by-digit square root chain
module npz_sqrt_cell #(
   parameter int XW = 8,
   parameter int RW = 4,
   parameter int K  = 0,
   parameter int SW = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  npz_pkg::ctl_type ctl_i,
   input  logic [XW-1:0]    x_i,
   input  logic [RW-1:0]    r_i,
   input  logic [SW-1:0]    side_i,
   output npz_pkg::ctl_type ctl_o,
   output logic [XW-1:0]    x_o,
   output logic [RW-1:0]    r_o,
   output logic [SW-1:0]    side_o
);
   localparam int TW = XW + RW + 2;

   npz_pkg::ctl_type ctl_ff;
   logic [TW-1:0]    trial;
   logic             fits;
   logic [XW-1:0]    x_ff, x_in;
   logic [RW-1:0]    r_ff, r_in;
   logic [SW-1:0]    side_ff;

   // (r + 2^k)^2 - r^2 = r * 2^(k+1) + 2^(2k)
   assign trial = (TW'(r_i) << (K + 1)) | (TW'(1) << (2 * K));
   assign fits  = TW'(x_i) >= trial;
   assign x_in  = fits ? XW'(TW'(x_i) - trial) : x_i;
   assign r_in  = fits ? (r_i | (RW'(1) << K)) : r_i;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         r_ff    <= r_in;
         side_ff <= side_i;
      end
   end

   assign ctl_o  = ctl_ff;
   assign x_o    = x_ff;
   assign r_o    = r_ff;
   assign side_o = side_ff;

endmodule

FILE: hdl/npz_div_cell.sv
// one quotient bit of the restoring divider chain
module npz_div_cell #(
   parameter int NW  = 8,
   parameter int DMW = 8,
   parameter int QW  = 4,
   parameter int K   = 0,
   parameter int SW  = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  npz_pkg::ctl_type ctl_i,
   input  logic [NW-1:0]    rem_i,
   input  logic [DMW-1:0]   den_i,
   input  logic [QW-1:0]    q_i,
   input  logic [SW-1:0]    side_i,
   output npz_pkg::ctl_type ctl_o,
   output logic [NW-1:0]    rem_o,
   output logic [DMW-1:0]   den_o,
   output logic [QW-1:0]    q_o,
   output logic [SW-1:0]    side_o
);
   localparam int CW = NW + DMW + QW + 1;

   npz_pkg::ctl_type ctl_ff;
   logic [CW-1:0]    shifted;
   logic             fits;
   logic [NW-1:0]    rem_ff, rem_in;
   logic [DMW-1:0]   den_ff;
   logic [QW-1:0]    q_ff, q_in;
   logic [SW-1:0]    side_ff;

   assign shifted = CW'(den_i) << K;
   assign fits    = CW'(rem_i) >= shifted;
   assign rem_in  = fits ? NW'(CW'(rem_i) - shifted) : rem_i;
   assign q_in    = fits ? (q_i | (QW'(1) << K)) : q_i;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         den_ff  <= den_i;
         q_ff    <= q_in;
         side_ff <= side_i;
      end
   end

   assign ctl_o  = ctl_ff;
   assign rem_o  = rem_ff;
   assign den_o  = den_ff;
   assign q_o    = q_ff;
   assign side_o = side_ff;

endmodule

FILE: hdl/neutrino_pz_w_mass_solver.sv
// neutrino pz solver top level: W-mass constraint quadratic, pipelined
//
//   port group  | dir | handshake             | carries
//   req_*       | in  | req_valid / req_ready | lepton four-momentum, mass, missing pt
//   rsp_*       | out | rsp_valid / rsp_ready | chosen neutrino pz, solved flag
//   csr_*       | in  | csr_valid / csr_ready | w_mass register write
//
// one item per cycle while the output buffer has room; the path from the input transfer
// to rsp_valid runs through the square root chain, RB cells where RB is half the
// discriminant width (one root bit per cell), and the divider chain (one quotient bit per cell).
// reset is synchronous; no clearing pass, w_mass returns to 80.4 GeV.
// a two-entry output buffer holds results; the whole pipe halts only while it is full.
`include "neutrino_pz_w_mass_solver_macros.svh"

module neutrino_pz_w_mass_solver #(
   parameter int MOMENTUM_BITS = 20
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [MOMENTUM_BITS-1:0] req_lepton_px,
   input  logic signed [MOMENTUM_BITS-1:0] req_lepton_py,
   input  logic signed [MOMENTUM_BITS-1:0] req_lepton_pz,
   input  logic [MOMENTUM_BITS-1:0]        req_lepton_energy,
   input  logic [15:0]                     req_lepton_mass,
   input  logic signed [MOMENTUM_BITS-1:0] req_missing_px,
   input  logic signed [MOMENTUM_BITS-1:0] req_missing_py,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [MOMENTUM_BITS-1:0] rsp_neutrino_pz,
   output logic                            rsp_solved,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [15:0]                     csr_w_mass
);
   localparam int N   = MOMENTUM_BITS;
   localparam int PW  = 2 * N;
   localparam int AW  = (2 * N + 3 > 35) ? 2 * N + 3 : 35;
   localparam int KW  = 2 * N + 2;
   localparam int TW  = 2 * N + 1;
   localparam int DW  = ((2 * AW > KW + TW + 2) ? 2 * AW : KW + TW + 2) + 1;
   localparam int XW  = DW - 1;
   localparam int RB  = DW / 2;
   localparam int APW = AW + N;
   localparam int ESW = N + RB + 2;
   localparam int NW  = ((APW > ESW) ? APW : ESW) + 1;
   localparam int DMW = KW + 1;
   localparam int OW  = NW + DMW + N;
   localparam int SW3 = APW + KW + N;
   localparam int SWE = APW + KW;

   logic adv;
   logic [15:0] w_mass_ff;

   // ---- stage 1: first products
   npz_pkg::ctl_type   ctl1_ff;
   logic [31:0]        w2_ff, m2_ff;
   logic signed [PW-1:0] pxmx_ff, pymy_ff, pz2_ff, mx2_ff, my2_ff;
   logic [PW-1:0]      e2_ff;
   logic [N-1:0]       e1_ff;
   logic signed [N-1:0] pz1_ff;

   // ---- stage 2: A, K, missing pt squared
   npz_pkg::ctl_type     ctl2_ff;
   logic signed [AW-1:0] a2_ff;
   logic signed [KW-1:0] k2_ff;
   logic signed [TW-1:0] t2_ff;
   logic [N-1:0]         e2v_ff;
   logic signed [N-1:0]  pz2v_ff;

   // ---- second products
   npz_pkg::ctl_type        ctl_m;
   logic signed [2*AW-1:0]  aa;
   logic signed [KW+TW-1:0] kt;
   logic signed [APW-1:0]   ap;
   logic [KW+N-1:0]         side_m;

   // ---- stage 3: discriminant
   logic signed [DW-1:0] disc;
   logic                 e_zero, d_neg, k_nonzero;
   npz_pkg::ctl_type     ctl3_ff;
   logic [XW-1:0]        x3_ff;
   logic [SW3-1:0]       side3_ff;

   // ---- sqrt chain
   npz_pkg::ctl_type sc [RB+1];
   logic [XW-1:0]    sx [RB+1];
   logic [RB-1:0]    sr [RB+1];
   logic [SW3-1:0]   ss [RB+1];

   // ---- E * S
   npz_pkg::ctl_type      ctl_e;
   logic signed [ESW-1:0] es;
   logic [SWE-1:0]        side_e;

   // ---- stage 4 / 5 / 6
   npz_pkg::ctl_type     ctl4_ff, ctl5_ff, ctl6_ff;
   logic signed [NW-1:0] n1_ff, n2_ff;
   logic signed [KW-1:0] k4_ff;
   logic [NW-1:0]        m1, m2;
   logic                 pick2;
   logic [KW-1:0]        k_mag;
   logic [NW-1:0]        nm5_ff, nm6_ff;
   logic [DMW-1:0]       dm5_ff, dm6_ff;
   logic                 neg5_ff, neg6_ff, ovf6_ff;

   // ---- divider chain
   npz_pkg::ctl_type dc [N+1];
   logic [NW-1:0]    dr [N+1];
   logic [DMW-1:0]   dd [N+1];
   logic [N-1:0]     dq [N+1];
   logic [1:0]       ds [N+1];

   // ---- final
   logic [N:0]   lim, qs;
   logic [N-1:0] fin_pz;
   logic         push, pop;
   logic         out_v_ff, skid_v_ff;
   logic [N-1:0] out_pz_ff, skid_pz_ff;
   logic         out_solved_ff, skid_solved_ff;

   assign adv       = !skid_v_ff;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_mass_ff <= npz_pkg::W_MASS_RESET;
      end else if (csr_valid) begin
         w_mass_ff <= csr_w_mass;
      end
   end

   // control stages of the top-level pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
         ctl5_ff <= '0;
         ctl6_ff <= '0;
      end else if (adv) begin
         ctl1_ff.valid  <= req_valid;
         ctl1_ff.solved <= 1'b0;
         ctl2_ff        <= ctl1_ff;
         ctl3_ff.valid  <= ctl_m.valid;
         ctl3_ff.solved <= (e_zero || !d_neg) && k_nonzero;
         ctl4_ff        <= ctl_e;
         ctl5_ff        <= ctl4_ff;
         ctl6_ff        <= ctl5_ff;
      end
   end

   assign disc      = DW'(aa) - (DW'(kt) << 2);
   assign e_zero    = side_m[N-1:0] == '0;
   assign d_neg     = disc[DW-1];
   assign k_nonzero = side_m[KW+N-1:N] != '0;

   assign m1    = n1_ff[NW-1] ? (NW'(~n1_ff) + NW'(1)) : NW'(n1_ff);
   assign m2    = n2_ff[NW-1] ? (NW'(~n2_ff) + NW'(1)) : NW'(n2_ff);
   assign pick2 = !(m1 < m2);
   assign k_mag = k4_ff[KW-1] ? (KW'(~k4_ff) + KW'(1)) : KW'(k4_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         w2_ff   <= w_mass_ff * w_mass_ff;
         m2_ff   <= req_lepton_mass * req_lepton_mass;
         pxmx_ff <= req_lepton_px * req_missing_px;
         pymy_ff <= req_lepton_py * req_missing_py;
         pz2_ff  <= req_lepton_pz * req_lepton_pz;
         mx2_ff  <= req_missing_px * req_missing_px;
         my2_ff  <= req_missing_py * req_missing_py;
         e2_ff   <= req_lepton_energy * req_lepton_energy;
         e1_ff   <= req_lepton_energy;
         pz1_ff  <= req_lepton_pz;

         a2_ff   <= AW'(w2_ff) - AW'(m2_ff) + ((AW'(pxmx_ff) + AW'(pymy_ff)) << 1);
         k2_ff   <= KW'(e2_ff) - KW'(pz2_ff);
         t2_ff   <= TW'(mx2_ff) + TW'(my2_ff);
         e2v_ff  <= e1_ff;
         pz2v_ff <= pz1_ff;

         // no sqrt when energy is zero or no real root
         x3_ff    <= (e_zero || d_neg) ? '0 : disc[XW-1:0];
         side3_ff <= {ap, side_m};

         n1_ff <= NW'($signed(side_e[SWE-1:KW])) + NW'(es);
         n2_ff <= NW'($signed(side_e[SWE-1:KW])) - NW'(es);
         k4_ff <= $signed(side_e[KW-1:0]);

         // smaller magnitude wins, tie goes to the second root
         nm5_ff  <= pick2 ? m2 : m1;
         neg5_ff <= (pick2 ? n2_ff[NW-1] : n1_ff[NW-1]) ^ k4_ff[KW-1];
         dm5_ff  <= DMW'(k_mag) << 1;

         nm6_ff  <= nm5_ff;
         dm6_ff  <= dm5_ff;
         neg6_ff <= neg5_ff;
         ovf6_ff <= OW'(nm5_ff) >= (OW'(dm5_ff) << N);
      end
   end

   npz_mul #(.WA(AW), .WB(N), .SW(KW + N)) u_mul_ap (
      .clock(clock), .reset(reset), .en(adv), .ctl_i(ctl2_ff),
      .a_i(a2_ff), .b_i(pz2v_ff), .side_i({k2_ff, e2v_ff}),
      .ctl_o(ctl_m), .p_o(ap), .side_o(side_m)
   );

   npz_mul #(.WA(AW), .WB(AW), .SW(1)) u_mul_aa (
      .clock(clock), .reset(reset), .en(adv), .ctl_i(ctl2_ff),
      .a_i(a2_ff), .b_i(a2_ff), .side_i(1'b0),
      .ctl_o(), .p_o(aa), .side_o()
   );

   npz_mul #(.WA(KW), .WB(TW), .SW(1)) u_mul_kt (
      .clock(clock), .reset(reset), .en(adv), .ctl_i(ctl2_ff),
      .a_i(k2_ff), .b_i(t2_ff), .side_i(1'b0),
      .ctl_o(), .p_o(kt), .side_o()
   );

   assign sc[0] = ctl3_ff;
   assign sx[0] = x3_ff;
   assign sr[0] = '0;
   assign ss[0] = side3_ff;

   for (genvar j = 0; j < RB; j++) begin : g_sqrt
      npz_sqrt_cell #(.XW(XW), .RW(RB), .K(RB - 1 - j), .SW(SW3)) u_cell (
         .clock(clock), .reset(reset), .en(adv),
         .ctl_i(sc[j]), .x_i(sx[j]), .r_i(sr[j]), .side_i(ss[j]),
         .ctl_o(sc[j+1]), .x_o(sx[j+1]), .r_o(sr[j+1]), .side_o(ss[j+1])
      );
   end

   npz_mul #(.WA(N + 1), .WB(RB + 1), .SW(SWE)) u_mul_es (
      .clock(clock), .reset(reset), .en(adv), .ctl_i(sc[RB]),
      .a_i($signed({1'b0, ss[RB][N-1:0]})), .b_i($signed({1'b0, sr[RB]})),
      .side_i(ss[RB][SW3-1:N]),
      .ctl_o(ctl_e), .p_o(es), .side_o(side_e)
   );

   assign dc[0] = ctl6_ff;
   assign dr[0] = nm6_ff;
   assign dd[0] = dm6_ff;
   assign dq[0] = '0;
   assign ds[0] = {neg6_ff, ovf6_ff};

   for (genvar j = 0; j < N; j++) begin : g_div
      npz_div_cell #(.NW(NW), .DMW(DMW), .QW(N), .K(N - 1 - j), .SW(2)) u_cell (
         .clock(clock), .reset(reset), .en(adv),
         .ctl_i(dc[j]), .rem_i(dr[j]), .den_i(dd[j]), .q_i(dq[j]), .side_i(ds[j]),
         .ctl_o(dc[j+1]), .rem_o(dr[j+1]), .den_o(dd[j+1]), .q_o(dq[j+1]),
         .side_o(ds[j+1])
      );
   end

   // saturate to the signed range, then apply the sign
   assign lim    = ds[N][1] ? ((N+1)'(1) << (N - 1)) : (((N+1)'(1) << (N - 1)) - (N+1)'(1));
   assign qs     = (ds[N][0] || ((N+1)'(dq[N]) > lim)) ? lim : (N+1)'(dq[N]);
   assign fin_pz = !dc[N].solved ? '0 : (ds[N][1] ? N'(~qs + (N+1)'(1)) : N'(qs));

   assign push = adv && dc[N].valid;
   assign pop  = out_v_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || pop) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= push;
         end
      end else if (push) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || pop) begin
         if (skid_v_ff) begin
            out_pz_ff     <= skid_pz_ff;
            out_solved_ff <= skid_solved_ff;
         end else begin
            out_pz_ff     <= fin_pz;
            out_solved_ff <= dc[N].solved;
         end
      end else if (push) begin
         skid_pz_ff     <= fin_pz;
         skid_solved_ff <= dc[N].solved;
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_neutrino_pz = $signed(out_pz_ff);
   assign rsp_solved      = out_solved_ff;

   `NPZ_ASSERT_SAME(a_unsolved_zero, clock, reset, rsp_valid && !rsp_solved, rsp_neutrino_pz == 0, "unsolved result with nonzero pz")
   `NPZ_ASSERT_SAME(a_skid_needs_out, clock, reset, skid_v_ff, out_v_ff, "skid entry held with empty output")
   `NPZ_ASSERT_SAME(a_skid_fill, clock, reset, $rose(skid_v_ff), $past(out_v_ff && !rsp_ready), "skid filled without output stall")

endmodule

FILE: verif/tb_neutrino_pz_w_mass_solver.sv
// testbench for the neutrino pz solver: directed table, random items, predictor check
`timescale 1ns / 1ps

module tb_neutrino_pz_w_mass_solver;

   localparam int MB = 20;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 200;

   typedef logic signed [191:0] big_type;

   typedef struct {
      logic signed [MB-1:0] px;
      logic signed [MB-1:0] py;
      logic signed [MB-1:0] pz;
      logic [MB-1:0]        energy;
      logic [15:0]          mass;
      logic signed [MB-1:0] mx;
      logic signed [MB-1:0] my;
      bit                   typed;
      logic signed [MB-1:0] want_pz;
      bit                   want_solved;
   } lepton_row_type;

   typedef struct {
      logic signed [MB-1:0] pz;
      bit                   solved;
   } nu_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [MB-1:0] req_lepton_px = '0;
   logic signed [MB-1:0] req_lepton_py = '0;
   logic signed [MB-1:0] req_lepton_pz = '0;
   logic [MB-1:0] req_lepton_energy = '0;
   logic [15:0] req_lepton_mass = '0;
   logic signed [MB-1:0] req_missing_px = '0;
   logic signed [MB-1:0] req_missing_py = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [MB-1:0] rsp_neutrino_pz;
   logic rsp_solved;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [15:0] csr_w_mass = '0;

   logic [15:0] w_mass_model;
   nu_result_type pending_pz[$];
   int errors = 0;
   int cycles = 0;
   int burst_left = 0;
   int stall_mode = 0;
   int stall_left = 0;

   neutrino_pz_w_mass_solver #(.MOMENTUM_BITS(MB)) dut (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic logic [191:0] floor_sqrt(logic [191:0] x);
      logic [191:0] r;
      logic [191:0] t;
      r = '0;
      for (int k = 95; k >= 0; k--) begin
         t = r | (192'd1 << k);
         if (t * t <= x) r = t;
      end
      return r;
   endfunction

   function automatic big_type mag(big_type v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic nu_result_type solve_pz(lepton_row_type it, logic [15:0] wm);
      nu_result_type res;
      big_type px, py, pz, en, ms, mx, my, w;
      big_type a, k, etm2, disc, sq, n1, n2, num, den, q, lim;
      bit neg;
      px = it.px; py = it.py; pz = it.pz; mx = it.mx; my = it.my;
      en = big_type'({1'b0, it.energy});
      ms = big_type'({1'b0, it.mass});
      w = big_type'({1'b0, wm});
      res.pz = '0;
      res.solved = 1'b0;
      a = w * w - ms * ms + 2 * (px * mx + py * my);
      k = en * en - pz * pz;
      etm2 = mx * mx + my * my;
      disc = a * a - 4 * k * etm2;
      if (en == 0) sq = 0;
      else if (disc < 0) return res;
      else sq = big_type'(floor_sqrt(disc));
      if (k == 0) return res;
      n1 = a * pz + en * sq;
      n2 = a * pz - en * sq;
      num = (mag(n1) < mag(n2)) ? n1 : n2;
      den = 2 * k;
      neg = (num < 0) != (den < 0);
      q = big_type'($unsigned(mag(num)) / $unsigned(mag(den)));
      lim = neg ? big_type'(1 << (MB - 1)) : big_type'((1 << (MB - 1)) - 1);
      if (q > lim) q = lim;
      if (neg) q = -q;
      res.pz = q[MB-1:0];
      res.solved = 1'b1;
      return res;
   endfunction

   // receiver: alternates between always-ready stretches and random stalls
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         if (pending_pz.size() == 0) begin
            $error("unexpected result transfer pz=%0d", rsp_neutrino_pz);
            errors++;
         end else begin
            if (rsp_neutrino_pz !== pending_pz[0].pz) begin
               $error("neutrino_pz expected %0d actual %0d", pending_pz[0].pz,
                      rsp_neutrino_pz);
               errors++;
            end
            if (rsp_solved !== pending_pz[0].solved) begin
               $error("solved expected %0d actual %0d", pending_pz[0].solved, rsp_solved);
               errors++;
            end
            void'(pending_pz.pop_front());
         end
      end
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(5, 60);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // called at a clock edge; returns at the edge where the transfer happened
   task automatic send_lepton(lepton_row_type it);
      int gap;
      nu_result_type exp_res;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_lepton_px <= it.px;
      req_lepton_py <= it.py;
      req_lepton_pz <= it.pz;
      req_lepton_energy <= it.energy;
      req_lepton_mass <= it.mass;
      req_missing_px <= it.mx;
      req_missing_py <= it.my;
      do @(posedge clock); while (!req_ready);
      if (it.typed) begin
         exp_res.pz = it.want_pz;
         exp_res.solved = it.want_solved;
      end else begin
         exp_res = solve_pz(it, w_mass_model);
      end
      pending_pz.insert(pending_pz.size(), exp_res);
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_pz.size() != 0);
   endtask

   task automatic write_w_mass(logic [15:0] v);
      drain_all();
      csr_valid <= 1'b1;
      csr_w_mass <= v;
      do @(posedge clock); while (!csr_ready);
      w_mass_model = v;
      csr_valid <= 1'b0;
   endtask

   function automatic int rand_signed(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic lepton_row_type random_lepton();
      lepton_row_type it;
      int span;
      int e;
      it.typed = 0;
      it.want_pz = '0;
      it.want_solved = 0;
      if ($urandom_range(0, 3) == 0) begin
         // raw noise over the whole field ranges
         it.px = MB'($urandom); it.py = MB'($urandom); it.pz = MB'($urandom);
         it.energy = MB'($urandom); it.mass = 16'($urandom);
         it.mx = MB'($urandom); it.my = MB'($urandom);
      end else begin
         case ($urandom_range(0, 2))
            0: span = 2000;
            1: span = 60000;
            default: span = 524287;
         endcase
         it.px = MB'(rand_signed(span));
         it.py = MB'(rand_signed(span));
         it.pz = MB'(rand_signed(span));
         e = (it.px < 0 ? -int'(it.px) : int'(it.px))
           + (it.py < 0 ? -int'(it.py) : int'(it.py))
           + (it.pz < 0 ? -int'(it.pz) : int'(it.pz)) + int'($urandom_range(0, span));
         it.energy = (e > 1048575) ? 20'hFFFFF : e[MB-1:0];
         it.mass = 16'($urandom_range(0, (span > 65535) ? 65535 : span));
         it.mx = MB'(rand_signed(span));
         it.my = MB'(rand_signed(span));
      end
      return it;
   endfunction

   lepton_row_type directed_rows[12];

   initial begin
      // zero energy and zero pz: degenerate denominator
      directed_rows[0] = '{0, 0, 0, 0, 0, 0, 0, 1, 0, 0};
      // energy equal to |pz|: no finite root
      directed_rows[1] = '{0, 0, -100, 100, 0, 0, 0, 1, 0, 0};
      // huge missing pt: negative discriminant
      directed_rows[2] = '{0, 0, 0, 500000, 0, 524287, 0, 1, 0, 0};
      directed_rows[3] = '{524287, 524287, 524287, 20'hFFFFF, 16'hFFFF, 524287, 524287,
                           0, 0, 0};
      directed_rows[4] = '{-524288, -524288, -524288, 0, 0, -524288, -524288, 0, 0, 0};
      // zero energy with nonzero pz
      directed_rows[5] = '{0, 0, 1000, 0, 0, 5000, 0, 0, 0, 0};
      directed_rows[6] = '{2000, 1000, 3000, 3742, 7, -1500, 2500, 0, 0, 0};
      // tiny denominator drives the root out of range
      directed_rows[7] = '{0, 0, 3000, 3001, 0, 100, 0, 0, 0, 0};
      directed_rows[8] = '{-524288, 524287, -3000, 700000, 16'hFFFF, 524287, -524288,
                           0, 0, 0};
      directed_rows[9] = '{-2500, 300, -8000, 9000, 6, 2600, -400, 0, 0, 0};
      directed_rows[10] = '{100, -100, 0, 200, 0, -100, 100, 0, 0, 0};
      directed_rows[11] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
      directed_rows[11].energy = 20'd1;

      w_mass_model = npz_pkg::W_MASS_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) send_lepton(directed_rows[i]);

      write_w_mass(16'hFFFF);
      foreach (directed_rows[i]) if (!directed_rows[i].typed) send_lepton(directed_rows[i]);
      for (int i = 0; i < 20; i++) send_lepton(random_lepton());
      write_w_mass(16'h0000);
      foreach (directed_rows[i]) if (!directed_rows[i].typed) send_lepton(directed_rows[i]);
      for (int i = 0; i < 20; i++) send_lepton(random_lepton());
      write_w_mass(16'($urandom));
      for (int i = 0; i < 100; i++) send_lepton(random_lepton());
      write_w_mass(npz_pkg::W_MASS_RESET);
      for (int i = 0; i < 310; i++) begin
         // hold off once until the pipe is empty
         if (i == 150) drain_all();
         send_lepton(random_lepton());
      end

      drain_all();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
